/* rtl/core/aspt_pkg.sv */
package aspt_pkg;

    // Field widths
    localparam int MEAS_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int CRUISE_W = 17;
    localparam int CMD_W    = 14;
    localparam int INTEG_W  = 18;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Output full scale in counts
    localparam int OUTPUT_FULL_SCALE = 9600;

    // Serial multiplier: 2-bit digits of a 16-bit multiplier
    localparam int DIGIT_W   = 2;
    localparam int MUL_STEPS = GAIN_W / DIGIT_W;
    localparam int CNT_W     = $clog2(MUL_STEPS);
    localparam int ACC_W     = 18;
    localparam int SUM_W     = ACC_W + DIGIT_W;

    // Register reset values
    localparam logic [MEAS_W-1:0]   TARGET_RST  = 16'd3840;
    localparam logic [GAIN_W-1:0]   GAIN_RST    = 16'd0;
    localparam logic [CRUISE_W-1:0] CRUISE_RST  = 17'd45875;
    localparam logic [CMD_W-1:0]    CMD_MIN_RST = 14'd0;
    localparam logic [CMD_W-1:0]    CMD_MAX_RST = 14'd9600;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET  = 3'd0,
        CFG_KP      = 3'd1,
        CFG_KI      = 3'd2,
        CFG_CRUISE  = 3'd3,
        CFG_CMD_MIN = 3'd4,
        CFG_CMD_MAX = 3'd5
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL1  = 5'b00010,
        S_INTEG = 5'b00100,
        S_MUL2  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // Control of one serial multiplier
    typedef struct packed {
        logic load;
        logic step;
    } t_mul_ctrl;

endpackage

/* rtl/core/aspt_if.sv */
interface aspt_in_if import aspt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MEAS_W-1:0] airspeed_measured;

    modport source (output valid, output airspeed_measured, input ready);
    modport sink   (input valid, input airspeed_measured, output ready);
endinterface

interface aspt_out_if import aspt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] throttle_out;

    modport source (output valid, output throttle_out, input ready);
    modport sink   (input valid, input throttle_out, output ready);
endinterface

/* rtl/core/aspt_digit_mul.sv */
// Radix-4 shift-add multiplier. Each step adds the lowest multiplier digit times
// the multiplicand to the high accumulator and shifts it right by one digit, so
// after all steps the accumulator holds floor(mcand * mplier / 2^16).
module aspt_digit_mul import aspt_pkg::*; (
    input  logic                    i_clk,
    input  t_mul_ctrl               i_ctrl,
    input  logic signed [ACC_W-1:0] i_mcand,
    input  logic [GAIN_W-1:0]       i_mplier,
    output logic signed [ACC_W-1:0] o_hi
);

    logic signed [ACC_W-1:0] r_mcand;
    logic [GAIN_W-1:0]       r_mplier;
    logic signed [ACC_W-1:0] r_hi;
    logic signed [SUM_W-1:0] mc_ext;
    logic signed [SUM_W-1:0] partial;
    logic signed [SUM_W-1:0] sum;

    // Digit times multiplicand, then add to the sign-extended accumulator
    always_comb begin
        mc_ext = SUM_W'(r_mcand);
        unique case (r_mplier[DIGIT_W-1:0])
            2'd0:    partial = '0;
            2'd1:    partial = mc_ext;
            2'd2:    partial = mc_ext <<< 1;
            default: partial = mc_ext + (mc_ext <<< 1);
        endcase
        sum = SUM_W'(r_hi) + partial;
    end

    // Load or step; the shifted-out low bits are never needed
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
            r_hi     <= '0;
        end else if (i_ctrl.step) begin
            r_mplier <= r_mplier >> DIGIT_W;
            r_hi     <= sum[SUM_W-1:DIGIT_W];
        end
    end

    assign o_hi = r_hi;

endmodule

/* rtl/core/airspeed_pi_throttle.sv */
// Channel      Direction  Payload              Handshake
// i_meas       in         airspeed_measured    valid / ready
// o_cmd        out        throttle_out         valid / ready
// i_cfg_*      in         index, data          write enable only
//
// A transaction is accepted in the idle state and its command is loaded into the output
// register in the finish state. In between come 8 radix-4 steps for the proportional and
// integral products, an integral update state, 8 steps for the feedforward product and
// the finish state. A new transaction is taken only after the finish state is left, so
// the two digit-serial multipliers, one of them shared, set how often one can start.
// Reset clears the integral, the sequencer and the output valid flag, and loads
// the register defaults. A stalled output holds the finished command in the
// finish state; the next measurement is taken while a result waits in o_cmd.
module airspeed_pi_throttle import aspt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    aspt_in_if.sink               i_meas,
    aspt_out_if.source            o_cmd
);

    localparam logic [GAIN_W-1:0] FULL_SCALE_MUL = GAIN_W'(OUTPUT_FULL_SCALE);
    localparam logic [CNT_W-1:0]  LAST_STEP      = CNT_W'(MUL_STEPS - 1);

    // Configuration registers
    logic [MEAS_W-1:0]   r_target;
    logic [GAIN_W-1:0]   r_kp;
    logic [GAIN_W-1:0]   r_ki;
    logic [CRUISE_W-1:0] r_cruise;
    logic [CMD_W-1:0]    r_cmd_min;
    logic [CMD_W-1:0]    r_cmd_max;

    // Control and state
    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic signed [INTEG_W-1:0] r_integ;
    logic                      r_out_valid;
    logic [CMD_W-1:0]          r_out_data;

    // Datapath
    logic                      in_fire;
    logic                      done_fire;
    logic signed [ACC_W-1:0]   err;
    t_mul_ctrl                 a_ctrl, b_ctrl;
    logic signed [ACC_W-1:0]   a_mcand;
    logic [GAIN_W-1:0]         a_mplier;
    logic signed [ACC_W-1:0]   a_hi, b_hi;
    logic [CRUISE_W-1:0]       cruise_sat;
    logic signed [INTEG_W:0]   integ_sum, integ_lo, integ_hi, integ_clamped;
    logic signed [INTEG_W:0]   ff_sum;
    logic [CMD_W-1:0]          ff_sat;
    logic signed [INTEG_W:0]   cmd_sum;
    logic [CMD_W-1:0]          cmd;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= TARGET_RST;
            r_kp      <= GAIN_RST;
            r_ki      <= GAIN_RST;
            r_cruise  <= CRUISE_RST;
            r_cmd_min <= CMD_MIN_RST;
            r_cmd_max <= CMD_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TARGET:  r_target  <= i_cfg_data[MEAS_W-1:0];
                CFG_KP:      r_kp      <= i_cfg_data[GAIN_W-1:0];
                CFG_KI:      r_ki      <= i_cfg_data[GAIN_W-1:0];
                CFG_CRUISE:  r_cruise  <= i_cfg_data[CRUISE_W-1:0];
                CFG_CMD_MIN: r_cmd_min <= i_cfg_data[CMD_W-1:0];
                CFG_CMD_MAX: r_cmd_max <= i_cfg_data[CMD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_meas.ready = (r_state == S_IDLE);
    assign in_fire      = i_meas.valid && i_meas.ready;
    assign done_fire    = (r_state == S_DONE) && (!r_out_valid || o_cmd.ready);

    // Speed error, target minus measured
    assign err = $signed({2'b00, r_target}) - $signed({2'b00, i_meas.airspeed_measured});

    // Integral update with clamp; cruise above one counts as one
    always_comb begin
        cruise_sat    = r_cruise[CRUISE_W-1] ? {1'b1, {(CRUISE_W-1){1'b0}}} : r_cruise;
        integ_sum     = (INTEG_W+1)'(r_integ) + (INTEG_W+1)'(a_hi);
        integ_lo      = -$signed({2'b00, cruise_sat});
        integ_hi      = $signed({2'b01, {(CRUISE_W-1){1'b0}}}) - $signed({2'b00, cruise_sat});
        priority if (integ_sum < integ_lo) begin
            integ_clamped = integ_lo;
        end else if (integ_sum > integ_hi) begin
            integ_clamped = integ_hi;
        end else begin
            integ_clamped = integ_sum;
        end
        ff_sum = integ_clamped + $signed({2'b00, cruise_sat});
    end

    // Multiplier A: integral product, then the feedforward product
    always_comb begin
        a_ctrl.load = in_fire || (r_state == S_INTEG);
        a_ctrl.step = (r_state == S_MUL1) || (r_state == S_MUL2);
        b_ctrl.load = in_fire;
        b_ctrl.step = (r_state == S_MUL1);
        if (r_state == S_INTEG) begin
            a_mcand  = $signed({1'b0, ff_sum[CRUISE_W-1:0]});
            a_mplier = FULL_SCALE_MUL;
        end else begin
            a_mcand  = err;
            a_mplier = r_ki;
        end
    end

    aspt_digit_mul u_mul_a (
        .i_clk    (i_clk),
        .i_ctrl   (a_ctrl),
        .i_mcand  (a_mcand),
        .i_mplier (a_mplier),
        .o_hi     (a_hi)
    );

    // Multiplier B: proportional product, held until the finish
    aspt_digit_mul u_mul_b (
        .i_clk    (i_clk),
        .i_ctrl   (b_ctrl),
        .i_mcand  (err),
        .i_mplier (r_kp),
        .o_hi     (b_hi)
    );

    // Feedforward limit, proportional sum and command limits
    always_comb begin
        priority if (a_hi < 0) begin
            ff_sat = '0;
        end else if (a_hi > $signed(ACC_W'(OUTPUT_FULL_SCALE))) begin
            ff_sat = CMD_W'(OUTPUT_FULL_SCALE);
        end else begin
            ff_sat = a_hi[CMD_W-1:0];
        end
        cmd_sum = $signed({{(INTEG_W+1-CMD_W){1'b0}}, ff_sat}) + (INTEG_W+1)'(b_hi);
        priority if (cmd_sum > $signed({{(INTEG_W+1-CMD_W){1'b0}}, r_cmd_max})) begin
            cmd = r_cmd_max;
        end else if (cmd_sum < $signed({{(INTEG_W+1-CMD_W){1'b0}}, r_cmd_min})) begin
            cmd = r_cmd_min;
        end else begin
            cmd = cmd_sum[CMD_W-1:0];
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (in_fire) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = S_INTEG;
                end
            end
            S_INTEG: begin
                n_cnt   = '0;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (done_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_integ <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == S_INTEG) begin
                r_integ <= integ_clamped[INTEG_W-1:0];
            end
        end
    end

    // Output register; a finished command waits here for its transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_cmd.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_fire) begin
            r_out_data <= cmd;
        end
    end

    assign o_cmd.valid        = r_out_valid;
    assign o_cmd.throttle_out = r_out_data;

endmodule
